// ----- sv/wsfp_pkg.sv -----
// Package for the wind sentence field parser.
// Character codes, field widths and the structs shared by the parser modules.
// No dependencies.
`default_nettype none

package wsfp_pkg;

	localparam logic [7:0] CH_DOLLAR  = 8'h24;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_POINT   = 8'h2E;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

	localparam int ANGLE_W = 14;
	localparam int SPEED_W = 24;
	localparam int ACC_W   = 24;
	localparam int COUNT_W = 16;
	localparam int CAP_W   = 3;
	localparam int FRAC_W  = 2;

	// Fraction digits kept per field
	localparam logic [FRAC_W-1:0] ANGLE_FRAC = 2'd1;
	localparam logic [FRAC_W-1:0] SPEED_FRAC = 2'd2;

	// Comma counter codes
	typedef enum logic [1:0] {
		COMMA_NONE  = 2'd0,
		COMMA_ONE   = 2'd1,
		COMMA_TWO   = 2'd2,
		COMMA_SPARE = 2'd3
	} comma_t;

	// Number to be scaled and clamped into a held field
	typedef struct packed {
		logic [ACC_W-1:0]  acc;
		logic [FRAC_W-1:0] frac_digits;
		logic              is_speed;
	} commit_req_t;

	// One finished line
	typedef struct packed {
		logic [ANGLE_W-1:0] angle_tenths;
		logic [SPEED_W-1:0] speed_hundredths;
		logic               line_was_sentence;
		logic [COUNT_W-1:0] line_count;
	} line_result_t;

endpackage

`default_nettype wire

// ----- sv/wsfp_rx_if.sv -----
// Character stream channel of the wind sentence field parser.
// Valid/ready handshake carrying one received byte. Depends on nothing.
`default_nettype none

interface wsfp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- sv/wsfp_line_if.sv -----
// Line result channel of the wind sentence field parser.
// Valid/ready handshake carrying the fields of one finished line. Uses wsfp_pkg.
`default_nettype none

interface wsfp_line_if;
	logic                          valid;
	logic                          ready;
	logic [wsfp_pkg::ANGLE_W-1:0]  angle_tenths;
	logic [wsfp_pkg::SPEED_W-1:0]  speed_hundredths;
	logic                          line_was_sentence;
	logic [wsfp_pkg::COUNT_W-1:0]  line_count;

	modport source (output valid, output angle_tenths, output speed_hundredths,
		output line_was_sentence, output line_count, input ready);
	modport sink   (input valid, input angle_tenths, input speed_hundredths,
		input line_was_sentence, input line_count, output ready);
endinterface

`default_nettype wire

// ----- sv/wsfp_commit.sv -----
// Fixed point commit: scales a decimal accumulator to tenths or hundredths
// and clamps it to the field maximum. Uses wsfp_pkg.
`default_nettype none

module wsfp_commit (
	input  wire wsfp_pkg::commit_req_t req,
	output logic [wsfp_pkg::SPEED_W-1:0] value
);

	localparam int PROD_W = wsfp_pkg::ACC_W + 7;

	logic [PROD_W-1:0] acc_ext;
	logic [PROD_W-1:0] scaled;
	logic [PROD_W-1:0] limit;

	assign acc_ext = PROD_W'(req.acc);

	always_comb begin
		// Missing fraction digits are made up by powers of ten
		if (req.is_speed) begin
			unique case (req.frac_digits)
				2'd0:    scaled = (acc_ext << 6) + (acc_ext << 5) + (acc_ext << 2);
				2'd1:    scaled = (acc_ext << 3) + (acc_ext << 1);
				default: scaled = acc_ext;
			endcase
			limit = PROD_W'({wsfp_pkg::SPEED_W{1'b1}});
		end else begin
			if (req.frac_digits == 2'd0) begin
				scaled = (acc_ext << 3) + (acc_ext << 1);
			end else begin
				scaled = acc_ext;
			end
			limit = PROD_W'({wsfp_pkg::ANGLE_W{1'b1}});
		end
	end

	assign value = (scaled > limit) ? limit[wsfp_pkg::SPEED_W-1:0]
		: scaled[wsfp_pkg::SPEED_W-1:0];

endmodule

`default_nettype wire

// ----- sv/wsfp_scan.sv -----
// Line scanner: holds the per-line scan state and the held field values,
// and works out one character per step. Uses wsfp_pkg and wsfp_commit.
`default_nettype none

module wsfp_scan #(
	parameter int ANGLE_CHARS = 3,
	parameter int SPEED_CHARS = 5
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          step,
	input  wire  [7:0]                   char_in,
	output logic                         line_done,
	output wsfp_pkg::line_result_t       line_res
);

	localparam int ACC_EXT_W = wsfp_pkg::ACC_W + 4;

	// Scan state
	logic                               at_line_start_q, in_sentence_q, scan_done_q;
	wsfp_pkg::comma_t                   comma_seen_q;
	logic [wsfp_pkg::CAP_W-1:0]         capture_left_q;
	logic                               capture_is_speed_q;
	logic                               digits_stopped_q, point_seen_q;
	logic [wsfp_pkg::FRAC_W-1:0]        fraction_digits_q;
	logic [wsfp_pkg::ACC_W-1:0]         acc_q;
	logic [wsfp_pkg::ANGLE_W-1:0]       held_angle_q;
	logic [wsfp_pkg::SPEED_W-1:0]       held_speed_q;
	logic [wsfp_pkg::COUNT_W-1:0]       lines_q;

	logic                               at_line_start_d, in_sentence_d, scan_done_d;
	wsfp_pkg::comma_t                   comma_seen_d;
	logic [wsfp_pkg::CAP_W-1:0]         capture_left_d;
	logic                               capture_is_speed_d;
	logic                               digits_stopped_d, point_seen_d;
	logic [wsfp_pkg::FRAC_W-1:0]        fraction_digits_d;
	logic [wsfp_pkg::ACC_W-1:0]         acc_d;
	logic [wsfp_pkg::ANGLE_W-1:0]       held_angle_d;
	logic [wsfp_pkg::SPEED_W-1:0]       held_speed_d;
	logic [wsfp_pkg::COUNT_W-1:0]       lines_d;

	// Digit feed, computed on the current number state
	logic                               is_digit;
	logic [ACC_EXT_W-1:0]               acc_times10;
	logic [wsfp_pkg::ACC_W-1:0]         acc_fed;
	logic                               stopped_fed, point_fed;
	logic [wsfp_pkg::FRAC_W-1:0]        frac_fed;
	logic [wsfp_pkg::FRAC_W-1:0]        frac_max;

	wsfp_pkg::commit_req_t              creq;
	logic [wsfp_pkg::SPEED_W-1:0]       cval;
	logic                               is_newline;

	assign is_newline = (char_in == wsfp_pkg::CH_NEWLINE);
	assign is_digit   = (char_in >= wsfp_pkg::CH_ZERO) && (char_in <= wsfp_pkg::CH_NINE);
	assign frac_max   = capture_is_speed_q ? wsfp_pkg::SPEED_FRAC : wsfp_pkg::ANGLE_FRAC;
	assign acc_times10 = (ACC_EXT_W'(acc_q) << 3) + (ACC_EXT_W'(acc_q) << 1)
		+ ACC_EXT_W'(char_in[3:0]);

	always_comb begin
		acc_fed     = acc_q;
		stopped_fed = digits_stopped_q;
		point_fed   = point_seen_q;
		frac_fed    = fraction_digits_q;
		if (!digits_stopped_q) begin
			if (is_digit) begin
				if (!point_seen_q || (fraction_digits_q < frac_max)) begin
					if (point_seen_q) begin
						frac_fed = fraction_digits_q + 2'd1;
					end
					acc_fed = (acc_times10 > ACC_EXT_W'({wsfp_pkg::ACC_W{1'b1}}))
						? {wsfp_pkg::ACC_W{1'b1}} : acc_times10[wsfp_pkg::ACC_W-1:0];
				end
			end else if ((char_in == wsfp_pkg::CH_POINT) && !point_seen_q) begin
				point_fed = 1'b1;
			end else begin
				stopped_fed = 1'b1;
			end
		end
	end

	// A newline commits what was read so far; a full window commits the fed value
	always_comb begin
		creq.is_speed = capture_is_speed_q;
		if (is_newline) begin
			creq.acc         = acc_q;
			creq.frac_digits = fraction_digits_q;
		end else begin
			creq.acc         = acc_fed;
			creq.frac_digits = frac_fed;
		end
	end

	wsfp_commit u_commit (
		.req   (creq),
		.value (cval)
	);

	always_comb begin
		at_line_start_d    = at_line_start_q;
		in_sentence_d      = in_sentence_q;
		scan_done_d        = scan_done_q;
		comma_seen_d       = comma_seen_q;
		capture_left_d     = capture_left_q;
		capture_is_speed_d = capture_is_speed_q;
		digits_stopped_d   = digits_stopped_q;
		point_seen_d       = point_seen_q;
		fraction_digits_d  = fraction_digits_q;
		acc_d              = acc_q;
		held_angle_d       = held_angle_q;
		held_speed_d       = held_speed_q;
		lines_d            = lines_q;

		priority if (is_newline) begin
			if (capture_left_q != '0) begin
				if (capture_is_speed_q) begin
					held_speed_d = cval;
				end else begin
					held_angle_d = cval[wsfp_pkg::ANGLE_W-1:0];
				end
			end
			lines_d            = lines_q + wsfp_pkg::COUNT_W'(1);
			at_line_start_d    = 1'b1;
			in_sentence_d      = 1'b0;
			scan_done_d        = 1'b0;
			comma_seen_d       = wsfp_pkg::COMMA_NONE;
			capture_left_d     = '0;
			capture_is_speed_d = 1'b0;
			digits_stopped_d   = 1'b0;
			point_seen_d       = 1'b0;
			fraction_digits_d  = '0;
			acc_d              = '0;
		end else if (at_line_start_q) begin
			at_line_start_d = 1'b0;
			in_sentence_d   = (char_in == wsfp_pkg::CH_DOLLAR);
		end else if (!in_sentence_q || scan_done_q) begin
			// drop the character
		end else if (capture_left_q != '0) begin
			capture_left_d    = capture_left_q - wsfp_pkg::CAP_W'(1);
			digits_stopped_d  = stopped_fed;
			point_seen_d      = point_fed;
			fraction_digits_d = frac_fed;
			acc_d             = acc_fed;
			if (capture_left_q == wsfp_pkg::CAP_W'(1)) begin
				if (capture_is_speed_q) begin
					held_speed_d = cval;
					scan_done_d  = 1'b1;
				end else begin
					held_angle_d = cval[wsfp_pkg::ANGLE_W-1:0];
				end
				digits_stopped_d  = 1'b0;
				point_seen_d      = 1'b0;
				fraction_digits_d = '0;
				acc_d             = '0;
			end
		end else if (char_in == wsfp_pkg::CH_STAR) begin
			scan_done_d = 1'b1;
		end else if (char_in == wsfp_pkg::CH_COMMA) begin
			unique case (comma_seen_q)
				wsfp_pkg::COMMA_NONE: begin
					capture_is_speed_d = 1'b0;
					capture_left_d     = wsfp_pkg::CAP_W'(ANGLE_CHARS);
					comma_seen_d       = wsfp_pkg::COMMA_ONE;
					digits_stopped_d   = 1'b0;
					point_seen_d       = 1'b0;
					fraction_digits_d  = '0;
					acc_d              = '0;
				end
				wsfp_pkg::COMMA_ONE: begin
					comma_seen_d = wsfp_pkg::COMMA_TWO;
				end
				default: begin
					capture_is_speed_d = 1'b1;
					capture_left_d     = wsfp_pkg::CAP_W'(SPEED_CHARS);
					digits_stopped_d   = 1'b0;
					point_seen_d       = 1'b0;
					fraction_digits_d  = '0;
					acc_d              = '0;
				end
			endcase
		end else begin
			// other characters outside a window are skipped
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_line_start_q    <= 1'b1;
			in_sentence_q      <= 1'b0;
			scan_done_q        <= 1'b0;
			comma_seen_q       <= wsfp_pkg::COMMA_NONE;
			capture_left_q     <= '0;
			capture_is_speed_q <= 1'b0;
			digits_stopped_q   <= 1'b0;
			point_seen_q       <= 1'b0;
			fraction_digits_q  <= '0;
			acc_q              <= '0;
			held_angle_q       <= '0;
			held_speed_q       <= '0;
			lines_q            <= '0;
		end else if (step) begin
			at_line_start_q    <= at_line_start_d;
			in_sentence_q      <= in_sentence_d;
			scan_done_q        <= scan_done_d;
			comma_seen_q       <= comma_seen_d;
			capture_left_q     <= capture_left_d;
			capture_is_speed_q <= capture_is_speed_d;
			digits_stopped_q   <= digits_stopped_d;
			point_seen_q       <= point_seen_d;
			fraction_digits_q  <= fraction_digits_d;
			acc_q              <= acc_d;
			held_angle_q       <= held_angle_d;
			held_speed_q       <= held_speed_d;
			lines_q            <= lines_d;
		end
	end

	assign line_done                  = is_newline;
	assign line_res.angle_tenths      = held_angle_d;
	assign line_res.speed_hundredths  = held_speed_d;
	assign line_res.line_was_sentence = in_sentence_q;
	assign line_res.line_count        = lines_d;

endmodule

`default_nettype wire

// ----- sv/wind_sentence_field_parser.sv -----
// Wind sentence field parser, top level. Uses wsfp_pkg, wsfp_rx_if, wsfp_line_if, wsfp_scan.
// A newline is held in the character register, then its line result is loaded into the output register.
// Throughput: one character per cycle, sustained, while the line channel keeps up.
// The character register stalls only when a line result waits untaken in the output register.
// Reset (arst_n low, asynchronous): scan state cleared, held angle/speed and line count zero,
// both pipeline valids dropped.
`default_nettype none

module wind_sentence_field_parser #(
	parameter int ANGLE_CHARS = 3,
	parameter int SPEED_CHARS = 5
) (
	input  wire              clk,
	input  wire              arst_n,
	wsfp_rx_if.sink          rx,
	wsfp_line_if.source      wind
);

	// Stage 1: the accepted character
	logic       valid_s1;
	logic [7:0] char_s1;

	// Output register: one finished line waiting for its transaction
	logic                   out_valid_q;
	wsfp_pkg::line_result_t out_q;

	logic                   advance;
	logic                   step;
	logic                   line_done;
	wsfp_pkg::line_result_t line_res;

	// The scanner moves whenever a character is held and the output register is free or being emptied.
	assign advance  = !out_valid_q || wind.ready;
	assign step     = valid_s1 && advance;
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	// Payload register: load on each accepted transaction, no reset needed
	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			char_s1 <= rx.rx_byte;
		end
	end

	wsfp_scan #(
		.ANGLE_CHARS (ANGLE_CHARS),
		.SPEED_CHARS (SPEED_CHARS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.char_in   (char_s1),
		.line_done (line_done),
		.line_res  (line_res)
	);

	// Hold a line result until taken; refill in the same cycle it drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && line_done;
		end
	end

	always_ff @(posedge clk) begin
		if (step && line_done) begin
			out_q <= line_res;
		end
	end

	assign wind.valid             = out_valid_q;
	assign wind.angle_tenths      = out_q.angle_tenths;
	assign wind.speed_hundredths  = out_q.speed_hundredths;
	assign wind.line_was_sentence = out_q.line_was_sentence;
	assign wind.line_count        = out_q.line_count;

endmodule

`default_nettype wire

// ----- sv/wsfp_checker.sv -----
// Port-level checks for the wind sentence field parser, bound to the top level.
// Uses wsfp_pkg; watches the rx and wind channels only.
`default_nettype none

module wsfp_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                rx_ready,
	input wire                                wind_valid,
	input wire                                wind_ready,
	input wire [wsfp_pkg::ANGLE_W-1:0]        angle_tenths,
	input wire [wsfp_pkg::SPEED_W-1:0]        speed_hundredths,
	input wire                                line_was_sentence,
	input wire [wsfp_pkg::COUNT_W-1:0]        line_count
);

	logic [wsfp_pkg::COUNT_W-1:0] count_q;
	logic [wsfp_pkg::ANGLE_W-1:0] prev_angle_q;
	logic [wsfp_pkg::SPEED_W-1:0] prev_speed_q;
	logic                         take;

	assign take = wind_valid && wind_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			prev_angle_q <= '0;
			prev_speed_q <= '0;
		end else if (take) begin
			count_q      <= line_count;
			prev_angle_q <= angle_tenths;
			prev_speed_q <= speed_hundredths;
		end
	end

	// A stalled line result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		wind_valid && !wind_ready |=> wind_valid && $stable(line_count)
			&& $stable(angle_tenths) && $stable(speed_hundredths))
		else $error("line result changed while stalled");

	// Each line carries the count of the one before plus one
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		wind_valid |-> line_count == count_q + wsfp_pkg::COUNT_W'(1))
		else $error("line count skipped or repeated");

	// A line that is no sentence leaves the held fields untouched
	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		wind_valid && !line_was_sentence |->
			angle_tenths == prev_angle_q && speed_hundredths == prev_speed_q)
		else $error("held field changed on a non-sentence line");

	// Input stalls only behind an untaken line result
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!rx_ready |-> wind_valid && !wind_ready)
		else $error("character channel stalled without cause");

endmodule

bind wind_sentence_field_parser wsfp_checker u_wsfp_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.rx_ready          (rx.ready),
	.wind_valid        (wind.valid),
	.wind_ready        (wind.ready),
	.angle_tenths      (wind.angle_tenths),
	.speed_hundredths  (wind.speed_hundredths),
	.line_was_sentence (wind.line_was_sentence),
	.line_count        (wind.line_count)
);

`default_nettype wire
